/* hdl/circle_intersection_area_top_defines.svh */
// assertion macros shared by the checker of the circle overlap block
`ifndef CIRCLE_INTERSECTION_AREA_TOP_DEFINES_SVH
`define CIRCLE_INTERSECTION_AREA_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define CIA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ciarea_pkg.sv */
// shared types, constants and tables of the circle overlap block
`default_nettype none
package ciarea_pkg;

  // overlap case codes
  localparam logic [1:0] CASE_APART  = 2'd0;
  localparam logic [1:0] CASE_INSIDE = 2'd1;
  localparam logic [1:0] CASE_LENS   = 2'd2;

  localparam logic [31:0] PI30     = 32'd3373259426;
  localparam logic [41:0] AREA_MAX = 42'h3FF_FFFF_FFFF;

  // pipeline lengths
  localparam int SQRT_STAGES    = 31;
  localparam int CORDIC_STEPS   = 30;
  localparam int CORDIC_LATENCY = CORDIC_STEPS + 5;
  localparam int ADJ_DELAY      = SQRT_STAGES + 1;
  localparam int HP_DELAY       = CORDIC_LATENCY;
  localparam int SIDE_DELAY     = SQRT_STAGES + 1 + CORDIC_LATENCY;

  // arctangent of 2^-i in Q2.30
  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
    30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
    30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
    30'd31, 30'd15, 30'd7, 30'd3, 30'd1
  };

  typedef struct packed {
    logic signed [23:0] center_a_x;
    logic signed [23:0] center_a_y;
    logic        [23:0] radius_a;
    logic signed [23:0] center_b_x;
    logic signed [23:0] center_b_y;
    logic        [23:0] radius_b;
  } ciarea_in_t;

  typedef struct packed {
    logic [41:0] overlap_area;
    logic [1:0]  overlap_case;
  } ciarea_out_t;

  // data that rides alongside the root and angle pipelines
  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] ra2;
    logic [47:0] rb2;
    logic [47:0] m2;
  } ciarea_side_t;

endpackage
`default_nettype wire

/* hdl/ciarea_delay.sv */
// enabled shift line that keeps side data aligned with the pipeline
`default_nettype none
module ciarea_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  // shift on every enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule
`default_nettype wire

/* hdl/ciarea_isqrt.sv */
// pipelined floor square root, one result bit per stage
`default_nettype none
module ciarea_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [61:0] radicand,
  output logic             out_valid,
  output logic      [30:0] root
);

  localparam int N = ciarea_pkg::SQRT_STAGES;

  logic [61:0] rem_q [N];
  logic [61:0] res_q [N];
  logic        vld_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [62:0] BIT = 63'(1) << (2 * (N - 1 - i));
    logic [61:0] rem_in;
    logic [61:0] res_in;
    logic        vld_in;
    logic [62:0] trial;

    if (i == 0) begin : g_first
      assign rem_in = radicand;
      assign res_in = '0;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign res_in = res_q[i-1];
      assign vld_in = vld_q[i-1];
    end

    assign trial = {1'b0, res_in} + BIT;

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_in;
      end
    end

    // restoring step
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[i] <= rem_in - trial[61:0];
          res_q[i] <= (res_in >> 1) + BIT[61:0];
        end else begin
          rem_q[i] <= rem_in;
          res_q[i] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = vld_q[N-1];
  assign root      = res_q[N-1][30:0];

endmodule
`default_nettype wire

/* hdl/ciarea_cordic.sv */
// half angle unit: scale alignment then vectoring cordic, one step per stage
`default_nettype none
module ciarea_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [51:0] adj,
  input  wire logic        [61:0] opp,
  output logic                    out_valid,
  output logic             [31:0] angle
);

  localparam int N = ciarea_pkg::CORDIC_STEPS;

  // stage 1: magnitude and doubling count
  logic [50:0] adj_mag;
  logic [4:0]  low_len;
  logic [4:0]  need;
  logic [3:0]  k_comb;
  logic        v1, neg1;
  logic [50:0] xv1;
  logic [61:0] yv1;
  logic [3:0]  k1;

  assign adj_mag = adj[51] ? 51'(-adj) : 51'(adj);

  always_comb begin
    low_len = '0;
    for (int b = 0; b < 30; b++) begin
      if (adj_mag[b]) begin
        low_len = 5'(b + 1);
      end
    end
  end

  assign need = 5'd30 - low_len;

  always_comb begin
    if (adj_mag[50:30] != '0) begin
      k_comb = 4'd0;
    end else if (need > 5'd12) begin
      k_comb = 4'd12;
    end else begin
      k_comb = need[3:0];
    end
  end

  // stage 2: apply doubling and the remaining halving of the opposite side
  logic        v2, neg2;
  logic [50:0] xs2;
  logic [61:0] ys2;

  // stage 3: common halving count
  logic [61:0] both;
  logic [5:0]  full_len;
  logic        v3, neg3;
  logic [50:0] xs3;
  logic [61:0] ys3;
  logic [5:0]  j3;

  assign both = {11'b0, xs2} | ys2;

  always_comb begin
    full_len = '0;
    for (int b = 0; b < 62; b++) begin
      if (both[b]) begin
        full_len = 6'(b + 1);
      end
    end
  end

  // stage 4: aligned start vector
  logic               v4, neg4;
  logic signed [33:0] x4, y4;
  logic [50:0]        xsh;
  logic [61:0]        ysh;

  assign xsh = xs3 >> j3;
  assign ysh = ys3 >> j3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // alignment datapath
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= adj[51];
      xv1  <= adj_mag;
      yv1  <= opp;
      k1   <= k_comb;
      neg2 <= neg1;
      xs2  <= xv1 << k1;
      ys2  <= yv1 >> (4'd12 - k1);
      neg3 <= neg2;
      xs3  <= xs2;
      ys3  <= ys2;
      j3   <= (full_len > 6'd30) ? full_len - 6'd30 : 6'd0;
      neg4 <= neg3;
      x4   <= {4'b0, xsh[29:0]};
      y4   <= {4'b0, ysh[29:0]};
    end
  end

  // rotation stages
  logic signed [33:0] cx_q [N];
  logic signed [33:0] cy_q [N];
  logic signed [33:0] cz_q [N];
  logic               cv_q [N];
  logic               cn_q [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [33:0] x_in, y_in, z_in;
    logic               v_in, n_in;

    if (i == 0) begin : g_first
      assign x_in = x4;
      assign y_in = y4;
      assign z_in = '0;
      assign v_in = v4;
      assign n_in = neg4;
    end else begin : g_next
      assign x_in = cx_q[i-1];
      assign y_in = cy_q[i-1];
      assign z_in = cz_q[i-1];
      assign v_in = cv_q[i-1];
      assign n_in = cn_q[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv_q[i] <= 1'b0;
      end else if (en) begin
        cv_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cn_q[i] <= n_in;
        if (!y_in[33]) begin
          cx_q[i] <= x_in + (y_in >>> i);
          cy_q[i] <= y_in - (x_in >>> i);
          cz_q[i] <= z_in + $signed({4'b0, ciarea_pkg::ATAN_TAB[i]});
        end else begin
          cx_q[i] <= x_in - (y_in >>> i);
          cy_q[i] <= y_in + (x_in >>> i);
          cz_q[i] <= z_in - $signed({4'b0, ciarea_pkg::ATAN_TAB[i]});
        end
      end
    end
  end

  // clamp and fold into the obtuse range
  logic [31:0] z_clamp;
  logic        v_out;
  logic [31:0] angle_q;

  assign z_clamp = cz_q[N-1][33] ? 32'd0 : cz_q[N-1][31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= cv_q[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_q <= cn_q[N-1] ? ciarea_pkg::PI30 - z_clamp : z_clamp;
    end
  end

  assign out_valid = v_out;
  assign angle     = angle_q;

endmodule
`default_nettype wire

/* hdl/circle_intersection_area_top.sv */
// circle overlap area of two circles, pipelined from item transfer to result valid
// throughput one item per cycle while results are taken
// a two-entry output buffer stalls the input only when both entries are full
// rst is synchronous, clears all valid bits and the output buffer
// payload registers are not reset
`default_nettype none
module circle_intersection_area_top (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire ciarea_pkg::ciarea_in_t item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output ciarea_pkg::ciarea_out_t     result
);

  logic en;
  logic skid_valid;
  ciarea_pkg::ciarea_out_t skid;

  assign en         = !skid_valid;
  assign item_stall = skid_valid;

  // stage 1: centre differences
  logic               s1_valid;
  logic signed [24:0] s1_dx, s1_dy;
  logic        [23:0] s1_ra, s1_rb;

  // stage 2: squares
  logic        [24:0] adx, ady, rsum;
  logic        [23:0] rdif, rmin;
  logic               s2_valid;
  logic        [49:0] s2_dx2, s2_dy2, s2_sum2;
  logic        [47:0] s2_dif2, s2_ra2, s2_rb2, s2_m2;

  assign adx  = s1_dx[24] ? 25'(-s1_dx) : 25'(s1_dx);
  assign ady  = s1_dy[24] ? 25'(-s1_dy) : 25'(s1_dy);
  assign rsum = 25'(s1_ra) + 25'(s1_rb);
  assign rdif = (s1_ra > s1_rb) ? s1_ra - s1_rb : s1_rb - s1_ra;
  assign rmin = (s1_ra < s1_rb) ? s1_ra : s1_rb;

  // stage 3: squared distance
  logic        s3_valid;
  logic [49:0] s3_d2, s3_sum2;
  logic [47:0] s3_dif2, s3_ra2, s3_rb2, s3_m2;

  // stage 4: case and root operands
  logic               s4_valid;
  logic [1:0]         kind_comb;
  logic [49:0]        pdiff, qdiff;
  logic [61:0]        s4_radp, s4_radq;
  logic signed [51:0] s4_na, s4_nb;
  ciarea_pkg::ciarea_side_t s4_side;

  assign pdiff = s3_sum2 - s3_d2;
  assign qdiff = s3_d2 - {2'b0, s3_dif2};

  always_comb begin
    if (s3_d2 >= s3_sum2) begin
      kind_comb = ciarea_pkg::CASE_APART;
    end else if (s3_d2 <= {2'b0, s3_dif2}) begin
      kind_comb = ciarea_pkg::CASE_INSIDE;
    end else begin
      kind_comb = ciarea_pkg::CASE_LENS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // front datapath
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx   <= {item.center_a_x[23], item.center_a_x}
               - {item.center_b_x[23], item.center_b_x};
      s1_dy   <= {item.center_a_y[23], item.center_a_y}
               - {item.center_b_y[23], item.center_b_y};
      s1_ra   <= item.radius_a;
      s1_rb   <= item.radius_b;
      s2_dx2  <= 50'(adx) * 50'(adx);
      s2_dy2  <= 50'(ady) * 50'(ady);
      s2_sum2 <= 50'(rsum) * 50'(rsum);
      s2_dif2 <= 48'(rdif) * 48'(rdif);
      s2_ra2  <= 48'(s1_ra) * 48'(s1_ra);
      s2_rb2  <= 48'(s1_rb) * 48'(s1_rb);
      s2_m2   <= 48'(rmin) * 48'(rmin);
      s3_d2   <= s2_dx2 + s2_dy2;
      s3_sum2 <= s2_sum2;
      s3_dif2 <= s2_dif2;
      s3_ra2  <= s2_ra2;
      s3_rb2  <= s2_rb2;
      s3_m2   <= s2_m2;
      s4_radp <= {pdiff, 12'b0};
      s4_radq <= {qdiff, 12'b0};
      s4_na   <= $signed({4'b0, s3_ra2}) + $signed({2'b0, s3_d2})
               - $signed({4'b0, s3_rb2});
      s4_nb   <= $signed({4'b0, s3_rb2}) + $signed({2'b0, s3_d2})
               - $signed({4'b0, s3_ra2});
      s4_side <= '{kind: kind_comb, ra2: s3_ra2, rb2: s3_rb2, m2: s3_m2};
    end
  end

  // square roots of both factors of the height product
  logic        sqa_valid, sqb_valid;
  logic [30:0] sqa_root, sqb_root;

  ciarea_isqrt u_sqrt_p (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .radicand  (s4_radp),
    .out_valid (sqa_valid),
    .root      (sqa_root)
  );

  ciarea_isqrt u_sqrt_q (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .radicand  (s4_radq),
    .out_valid (sqb_valid),
    .root      (sqb_root)
  );

  // height product stage
  logic        h_valid;
  logic [61:0] h_hp;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= sqa_valid && sqb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_hp <= 62'(sqa_root) * 62'(sqb_root);
    end
  end

  // adjacent sides follow the roots
  logic [103:0] adj_d;

  ciarea_delay #(.W(104), .DEPTH(ciarea_pkg::ADJ_DELAY)) u_adj_delay (
    .clk (clk),
    .en  (en),
    .d   ({s4_na, s4_nb}),
    .q   (adj_d)
  );

  // half angles of both circles
  logic        ca_valid, cb_valid;
  logic [31:0] ta, tb;

  ciarea_cordic u_cordic_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (h_valid),
    .adj       ($signed(adj_d[103:52])),
    .opp       (h_hp),
    .out_valid (ca_valid),
    .angle     (ta)
  );

  ciarea_cordic u_cordic_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (h_valid),
    .adj       ($signed(adj_d[51:0])),
    .opp       (h_hp),
    .out_valid (cb_valid),
    .angle     (tb)
  );

  logic [61:0] hp_d;
  ciarea_pkg::ciarea_side_t side_d;

  ciarea_delay #(.W(62), .DEPTH(ciarea_pkg::HP_DELAY)) u_hp_delay (
    .clk (clk),
    .en  (en),
    .d   (h_hp),
    .q   (hp_d)
  );

  ciarea_delay #(
    .W     ($bits(ciarea_pkg::ciarea_side_t)),
    .DEPTH (ciarea_pkg::SIDE_DELAY)
  ) u_side_delay (
    .clk (clk),
    .en  (en),
    .d   (s4_side),
    .q   (side_d)
  );

  // operand selection per case
  logic [47:0] sel_a, sel_b;
  logic [31:0] sel_ta, sel_tb;
  logic [61:0] sel_h;

  always_comb begin
    case (side_d.kind)
      ciarea_pkg::CASE_LENS: begin
        sel_a  = side_d.ra2;
        sel_ta = ta;
        sel_b  = side_d.rb2;
        sel_tb = tb;
        sel_h  = hp_d;
      end
      ciarea_pkg::CASE_INSIDE: begin
        sel_a  = side_d.m2;
        sel_ta = ciarea_pkg::PI30;
        sel_b  = '0;
        sel_tb = '0;
        sel_h  = '0;
      end
      default: begin
        sel_a  = '0;
        sel_ta = '0;
        sel_b  = '0;
        sel_tb = '0;
        sel_h  = '0;
      end
    endcase
  end

  // back end: split products, rounding, subtraction and saturation
  logic        f1_valid, f2_valid, f3_valid;
  logic [55:0] f1_la, f1_ha, f1_lb, f1_hb;
  logic [41:0] f1_neg, f2_neg;
  logic [1:0]  f1_kind, f2_kind;
  logic [62:0] neg_sum;
  logic [56:0] lo_a, lo_b;
  logic [42:0] f2_ma, f2_mb;
  logic [43:0] pos, diff;
  ciarea_pkg::ciarea_out_t f3_res;

  assign neg_sum = 63'(sel_h) + (63'(1) << 20);
  assign lo_a    = 57'(f1_la) + (57'(1) << 37);
  assign lo_b    = 57'(f1_lb) + (57'(1) << 37);
  assign pos     = 44'(f2_ma) + 44'(f2_mb);
  assign diff    = (pos > 44'(f2_neg)) ? pos - 44'(f2_neg) : 44'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= ca_valid && cb_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_la   <= 56'(sel_a[23:0]) * 56'(sel_ta);
      f1_ha   <= 56'(sel_a[47:24]) * 56'(sel_ta);
      f1_lb   <= 56'(sel_b[23:0]) * 56'(sel_tb);
      f1_hb   <= 56'(sel_b[47:24]) * 56'(sel_tb);
      f1_neg  <= neg_sum[62:21];
      f1_kind <= side_d.kind;
      f2_ma   <= 43'((57'(f1_ha) + 57'(lo_a[56:24])) >> 14);
      f2_mb   <= 43'((57'(f1_hb) + 57'(lo_b[56:24])) >> 14);
      f2_neg  <= f1_neg;
      f2_kind <= f1_kind;
      f3_res.overlap_area <= (diff > 44'(ciarea_pkg::AREA_MAX))
                           ? ciarea_pkg::AREA_MAX : diff[41:0];
      f3_res.overlap_case <= f2_kind;
    end
  end

  // output register and skid entry
  logic take;
  logic push;

  assign take = result_valid && !result_stall;
  assign push = en && f3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        result     <= skid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!result_valid || take) begin
        result       <= f3_res;
        result_valid <= 1'b1;
      end else begin
        skid       <= f3_res;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* hdl/ciarea_checker.sv */
// port-level checks of the circle overlap block, bound to the top level
`default_nettype none
`include "circle_intersection_area_top_defines.svh"
module ciarea_checker (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    item_valid,
  input wire logic                    item_stall,
  input wire logic                    result_valid,
  input wire logic                    result_stall,
  input wire ciarea_pkg::ciarea_out_t result
);

  logic item_transfer;
  assign item_transfer = item_valid && !item_stall;

  // a waiting result holds
  `CIA_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
    result_valid && $stable(result), "result changed while stalled")

  // input only backs up behind a stalled result
  `CIA_ASSERT_NOW(a_stall_cause, item_stall,
    $past(result_valid) && $past(result_stall), "input stalled without output stall")

  // apart circles share no area
  `CIA_ASSERT_NOW(a_apart_zero,
    result_valid && result.overlap_case == ciarea_pkg::CASE_APART,
    result.overlap_area == 42'd0, "nonzero area for apart circles")

  // nothing comes out right after reset
  `CIA_ASSERT_NOW(a_reset_empty, result_valid || item_transfer,
    !$past(rst) || item_transfer, "result valid right after reset")

endmodule

bind circle_intersection_area_top ciarea_checker u_ciarea_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
`default_nettype wire
